[hdl/dfr_pkg.sv]
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared types, constants and width helpers for the regression delta block.
// ----------------------------------------------------------------------------
package dfr_pkg;

  localparam int unsigned SAMPLE_BITS         = 16;
  localparam int unsigned DELTA_BITS          = 24;
  localparam int unsigned HW_BITS             = 4;
  localparam int unsigned MAX_HALF_WINDOW_DEF = 8;
  localparam int unsigned QUEUE_DEPTH_DEF     = 4;
  localparam logic [HW_BITS-1:0] HW_RESET     = 4'd2;

  localparam int unsigned DELTA_MAX_MAG = 8388607;
  localparam int unsigned DELTA_MIN_MAG = 8388608;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [DELTA_BITS-1:0] delta_value;
    logic                         end_of_sequence;
  } out_item_t;

  // numerator: sum of n*(x_fut - x_past), n = 1..m
  function automatic int unsigned num_width(int unsigned m);
    return SAMPLE_BITS + 2 + $clog2(m * (m + 1) / 2 + 1);
  endfunction

  // sum of n^2, n = 1..m
  function automatic int unsigned sq_width(int unsigned m);
    return $clog2(m * (m + 1) * (2 * m + 1) / 6 + 1);
  endfunction

endpackage

[hdl/dfr_ram.sv]
// ----------------------------------------------------------------------------
// dfr_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module dfr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

[hdl/dfr_front.sv]
// ----------------------------------------------------------------------------
// dfr_front
// Takes samples into the history RAM, decides which positions are due and
// accumulates each position's numerator and weight sum, one tap per cycle.
// ----------------------------------------------------------------------------
module dfr_front #(
  parameter int unsigned MAX_HW = dfr_pkg::MAX_HALF_WINDOW_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic [dfr_pkg::HW_BITS-1:0]                   half_window_i,
  input  dfr_pkg::in_item_t                             in_item_i,
  input  logic                                          in_valid_i,
  output logic                                          in_ready_o,
  output logic                                          job_valid_o,
  input  logic                                          job_ready_i,
  output logic signed [dfr_pkg::num_width(MAX_HW)-1:0]  job_num_o,
  output logic [dfr_pkg::sq_width(MAX_HW)-1:0]          job_sq_o,
  output logic                                          job_eos_o
);
  import dfr_pkg::*;

  localparam int unsigned S       = SAMPLE_BITS;
  localparam int unsigned K_W     = $clog2(MAX_HW + 1);
  localparam int unsigned AGE_W   = $clog2(2 * MAX_HW + 1);
  localparam int unsigned CNT_W   = $clog2(2 * MAX_HW + 2);
  localparam int unsigned CNT_MAX = 2 * MAX_HW + 1;
  localparam int unsigned DEPTH   = 1 << AGE_W;
  localparam int unsigned NUM_W   = num_width(MAX_HW);
  localparam int unsigned SQ_W    = sq_width(MAX_HW);
  localparam int unsigned PROD_W  = S + 2 + K_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_PUSH
  } state_e;

  state_e                   state_q, state_d;
  logic                     in_seq_q, in_seq_d;
  logic [K_W-1:0]           seen_q, seen_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [AGE_W-1:0]         head_q, head_d;
  logic signed [S-1:0]      first_q, first_d;
  logic [K_W-1:0]           k_q, k_d;
  logic                     main_q, main_d;
  logic                     flush_q, flush_d;
  logic [K_W-1:0]           d_q, d_d;
  logic [K_W-1:0]           n_q, n_d;
  logic                     issued_q, issued_d;
  logic                     p_valid_q, p_valid_d;
  logic [K_W-1:0]           p_n_q, p_n_d;
  logic                     p_last_q, p_last_d;
  logic                     p_fut_first_q, p_fut_first_d;
  logic                     p_past_first_q, p_past_first_d;
  logic signed [NUM_W-1:0]  acc_q, acc_d;
  logic [SQ_W-1:0]          sq_q, sq_d;

  logic [K_W-1:0]           k_eff;
  logic [K_W-1:0]           seen_now;
  logic [K_W:0]             pend;
  logic [K_W:0]             seen_inc;
  logic [K_W-1:0]           cur_d;
  logic [K_W-1:0]           fut_age;
  logic [K_W:0]             past_age;
  logic [AGE_W-1:0]         raddr_a, raddr_b;
  logic                     ram_we;
  logic [S-1:0]             rdata_a, rdata_b;
  logic signed [S-1:0]      fut_v, past_v;
  logic signed [S:0]        diff;
  logic signed [PROD_W-1:0] term;
  logic [2*K_W-1:0]         n_sq;

  dfr_ram #(
    .WIDTH (S),
    .DEPTH (DEPTH)
  ) u_hist (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (head_d),
    .wdata_i   (in_item_i.sample),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  always_comb begin
    if (half_window_i == '0) begin
      k_eff = K_W'(1);
    end else if (32'(half_window_i) > MAX_HW) begin
      k_eff = K_W'(MAX_HW);
    end else begin
      k_eff = K_W'(half_window_i);
    end
  end

  assign seen_now = in_seq_q ? seen_q : '0;
  assign seen_inc = {1'b0, seen_now} + 1'b1;
  assign pend     = (seen_inc > {1'b0, k_eff}) ? {1'b0, k_eff} : seen_inc;

  assign cur_d    = main_q ? k_q : d_q;
  assign fut_age  = (cur_d > n_q) ? (cur_d - n_q) : '0;
  assign past_age = {1'b0, cur_d} + {1'b0, n_q};
  assign raddr_a  = head_q - AGE_W'(fut_age);
  assign raddr_b  = head_q - AGE_W'(past_age);

  // ages beyond the start of the sequence read as the first sample
  assign fut_v  = p_fut_first_q ? first_q : $signed(rdata_a);
  assign past_v = p_past_first_q ? first_q : $signed(rdata_b);
  assign diff   = (S + 1)'(fut_v) - (S + 1)'(past_v);
  assign term   = $signed({1'b0, p_n_q}) * diff;
  assign n_sq   = p_n_q * p_n_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign job_valid_o = (state_q == ST_PUSH);
  assign job_num_o   = acc_q;
  assign job_sq_o    = sq_q;
  assign job_eos_o   = !main_q && (d_q == '0);

  always_comb begin
    state_d        = state_q;
    in_seq_d       = in_seq_q;
    seen_d         = seen_q;
    cnt_d          = cnt_q;
    head_d         = head_q;
    first_d        = first_q;
    k_d            = k_q;
    main_d         = main_q;
    flush_d        = flush_q;
    d_d            = d_q;
    n_d            = n_q;
    issued_d       = issued_q;
    p_valid_d      = 1'b0;
    p_n_d          = p_n_q;
    p_last_d       = p_last_q;
    p_fut_first_d  = p_fut_first_q;
    p_past_first_d = p_past_first_q;
    acc_d          = acc_q;
    sq_d           = sq_q;
    ram_we         = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ram_we   = 1'b1;
          head_d   = head_q + 1'b1;
          k_d      = k_eff;
          main_d   = (seen_now >= k_eff);
          flush_d  = in_item_i.is_last;
          d_d      = K_W'(pend - 1'b1);
          n_d      = K_W'(1);
          issued_d = 1'b0;
          acc_d    = '0;
          sq_d     = '0;
          if (!in_seq_q) begin
            first_d = in_item_i.sample;
            cnt_d   = CNT_W'(1);
          end else if (32'(cnt_q) < CNT_MAX) begin
            cnt_d = cnt_q + 1'b1;
          end
          if (in_item_i.is_last) begin
            in_seq_d = 1'b0;
            seen_d   = '0;
          end else begin
            in_seq_d = 1'b1;
            seen_d   = (32'(seen_now) < MAX_HW) ? K_W'(seen_inc) : seen_now;
          end
          if ((seen_now >= k_eff) || in_item_i.is_last) begin
            state_d = ST_RUN;
          end
        end
      end

      ST_RUN: begin
        if (!issued_q) begin
          p_valid_d      = 1'b1;
          p_n_d          = n_q;
          p_last_d       = (n_q == k_q);
          p_fut_first_d  = (32'(fut_age) >= 32'(cnt_q));
          p_past_first_d = (32'(past_age) >= 32'(cnt_q));
          if (n_q == k_q) begin
            issued_d = 1'b1;
          end else begin
            n_d = n_q + 1'b1;
          end
        end
        if (p_valid_q) begin
          acc_d = acc_q + NUM_W'(term);
          sq_d  = sq_q + SQ_W'(n_sq);
          if (p_last_q) begin
            state_d = ST_PUSH;
          end
        end
      end

      ST_PUSH: begin
        if (job_ready_i) begin
          n_d      = K_W'(1);
          issued_d = 1'b0;
          acc_d    = '0;
          sq_d     = '0;
          if (main_q) begin
            main_d  = 1'b0;
            state_d = flush_q ? ST_RUN : ST_IDLE;
          end else if (d_q == '0) begin
            flush_d = 1'b0;
            state_d = ST_IDLE;
          end else begin
            d_d     = d_q - 1'b1;
            state_d = ST_RUN;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      in_seq_q  <= 1'b0;
      seen_q    <= '0;
      cnt_q     <= '0;
      head_q    <= '0;
      main_q    <= 1'b0;
      flush_q   <= 1'b0;
      issued_q  <= 1'b0;
      p_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      in_seq_q  <= in_seq_d;
      seen_q    <= seen_d;
      cnt_q     <= cnt_d;
      head_q    <= head_d;
      main_q    <= main_d;
      flush_q   <= flush_d;
      issued_q  <= issued_d;
      p_valid_q <= p_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q        <= first_d;
    k_q            <= k_d;
    d_q            <= d_d;
    n_q            <= n_d;
    p_n_q          <= p_n_d;
    p_last_q       <= p_last_d;
    p_fut_first_q  <= p_fut_first_d;
    p_past_first_q <= p_past_first_d;
    acc_q          <= acc_d;
    sq_q           <= sq_d;
  end

endmodule

[hdl/dfr_queue.sv]
// ----------------------------------------------------------------------------
// dfr_queue
// Small FIFO of pending positions between the front and the back.
// ----------------------------------------------------------------------------
module dfr_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = dfr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import dfr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d;
  logic [PTR_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (32'(cnt_q) < DEPTH);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = data_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (32'(wr_q) == DEPTH - 1) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (32'(rd_q) == DEPTH - 1) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      data_q[wr_q] <= push_data_i;
    end
  end

endmodule

[hdl/dfr_back.sv]
// ----------------------------------------------------------------------------
// dfr_back
// Scales one position's numerator by its weight sum with a radix-2 divider,
// rounds to nearest, saturates and holds the item in the output register.
// ----------------------------------------------------------------------------
module dfr_back #(
  parameter int unsigned MAX_HW = dfr_pkg::MAX_HALF_WINDOW_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          job_valid_i,
  output logic                                          job_ready_o,
  input  logic signed [dfr_pkg::num_width(MAX_HW)-1:0]  job_num_i,
  input  logic [dfr_pkg::sq_width(MAX_HW)-1:0]          job_sq_i,
  input  logic                                          job_eos_i,
  output dfr_pkg::out_item_t                            out_item_o,
  output logic                                          out_valid_o,
  input  logic                                          out_ready_i
);
  import dfr_pkg::*;

  localparam int unsigned NUM_W = num_width(MAX_HW);
  localparam int unsigned SQ_W  = sq_width(MAX_HW);
  localparam int unsigned DV_W  = NUM_W + 10;
  localparam int unsigned Q_W   = DV_W - 1;
  localparam int unsigned V_W   = SQ_W + 2;
  localparam int unsigned R_W   = V_W + 1;
  localparam int unsigned IT_W  = $clog2(Q_W + 1);
  localparam int unsigned MAG_W = (Q_W > DELTA_BITS) ? Q_W + 1 : DELTA_BITS + 1;
  localparam logic [MAG_W-1:0] MAG_MAX = MAG_W'(DELTA_MAX_MAG);
  localparam logic [MAG_W-1:0] MAG_MIN = MAG_W'(DELTA_MIN_MAG);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_OUT
  } state_e;

  state_e                  state_q, state_d;
  logic [Q_W-1:0]          quot_q, quot_d;
  logic [V_W-1:0]          rem_q, rem_d;
  logic [V_W-1:0]          div_q, div_d;
  logic [IT_W-1:0]         it_q, it_d;
  logic                    neg_q, neg_d;
  logic                    eos_q, eos_d;
  logic [MAG_W-1:0]        mag_q, mag_d;
  out_item_t               out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  logic signed [DV_W-1:0]  dividend;
  logic [DV_W-1:0]         dv_abs;
  logic [R_W-1:0]          trial;
  logic                    fits;
  logic [DELTA_BITS-1:0]   mag_low;

  // num*512 + 2*sq over 4*sq gives round-to-nearest of num*256/(2*sq)
  assign dividend = (DV_W'(job_num_i) <<< 9) + $signed(DV_W'({job_sq_i, 1'b0}));
  assign dv_abs   = dividend[DV_W-1] ? DV_W'(-dividend) : DV_W'(dividend);
  assign trial    = {rem_q, quot_q[Q_W-1]};
  assign fits     = (trial >= R_W'(div_q));
  assign mag_low  = mag_q[DELTA_BITS-1:0];

  assign job_ready_o = (state_q == ST_IDLE);
  assign out_item_o  = out_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    quot_d      = quot_q;
    rem_d       = rem_q;
    div_d       = div_q;
    it_d        = it_q;
    neg_d       = neg_q;
    eos_d       = eos_q;
    mag_d       = mag_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          quot_d  = dv_abs[Q_W-1:0];
          rem_d   = '0;
          div_d   = {job_sq_i, 2'b00};
          neg_d   = dividend[DV_W-1];
          eos_d   = job_eos_i;
          it_d    = IT_W'(Q_W);
          state_d = ST_DIV;
        end
      end

      ST_DIV: begin
        quot_d = {quot_q[Q_W-2:0], fits};
        rem_d  = fits ? V_W'(trial - R_W'(div_q)) : V_W'(trial);
        it_d   = it_q - 1'b1;
        if (it_q == IT_W'(1)) begin
          state_d = ST_FIX;
        end
      end

      ST_FIX: begin
        // floor of a negative quotient rounds the magnitude up
        mag_d   = MAG_W'(quot_q) + MAG_W'(neg_q && (rem_q != '0));
        state_d = ST_OUT;
      end

      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          if (neg_q) begin
            out_d.delta_value = (mag_q > MAG_MIN) ? $signed(DELTA_BITS'(MAG_MIN))
                                                  : $signed(-mag_low);
          end else begin
            out_d.delta_value = (mag_q > MAG_MAX) ? $signed(DELTA_BITS'(MAG_MAX))
                                                  : $signed(mag_low);
          end
          out_d.end_of_sequence = eos_q;
          out_valid_d           = 1'b1;
          state_d               = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
    it_q   <= it_d;
    neg_q  <= neg_d;
    eos_q  <= eos_d;
    mag_q  <= mag_d;
    out_q  <= out_d;
  end

endmodule

[hdl/delta_feature_regression.sv]
// ----------------------------------------------------------------------------
// delta_feature_regression
// Streaming regression delta of one sample sequence, 8 fraction bits.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries one signed sample and a last
// flag. Output channel (out_valid_o/out_ready_i) carries one delta and an
// end-of-sequence flag. cfg_we_i writes the half window K from cfg_wdata_i;
// write it only while the block is idle.
// The front stores samples in a history RAM and, per due position, sums the
// K taps at one tap per cycle. An item releases no position or one, or up to
// K+1 on the last sample. Positions wait in a small queue. The back divides
// with one quotient bit per cycle and takes no new position until it has
// passed the last result to the output register.
// Reset closes any open sequence, empties the queue and output register
// and sets K to 2. A stalled receiver holds the output register; the back
// and then the queue and the front stall behind it, losing nothing.
// ----------------------------------------------------------------------------
module delta_feature_regression #(
  parameter int unsigned MAX_HALF_WINDOW = dfr_pkg::MAX_HALF_WINDOW_DEF,
  parameter int unsigned QUEUE_DEPTH     = dfr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dfr_pkg::HW_BITS-1:0] cfg_wdata_i,
  input  dfr_pkg::in_item_t           in_item_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  output dfr_pkg::out_item_t          out_item_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i
);
  import dfr_pkg::*;

  localparam int unsigned NUM_W = num_width(MAX_HALF_WINDOW);
  localparam int unsigned SQ_W  = sq_width(MAX_HALF_WINDOW);
  localparam int unsigned JOB_W = NUM_W + SQ_W + 1;

  logic [HW_BITS-1:0]      half_window_q;
  logic                    f_valid, f_ready;
  logic signed [NUM_W-1:0] f_num;
  logic [SQ_W-1:0]         f_sq;
  logic                    f_eos;
  logic                    b_valid, b_ready;
  logic [JOB_W-1:0]        b_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_window_q <= HW_RESET;
    end else if (cfg_we_i) begin
      half_window_q <= cfg_wdata_i;
    end
  end

  dfr_front #(
    .MAX_HW (MAX_HALF_WINDOW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .half_window_i (half_window_q),
    .in_item_i     (in_item_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .job_valid_o   (f_valid),
    .job_ready_i   (f_ready),
    .job_num_o     (f_num),
    .job_sq_o      (f_sq),
    .job_eos_o     (f_eos)
  );

  dfr_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  ({f_num, f_sq, f_eos}),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_data)
  );

  dfr_back #(
    .MAX_HW (MAX_HALF_WINDOW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (b_valid),
    .job_ready_o (b_ready),
    .job_num_i   ($signed(b_data[JOB_W-1 -: NUM_W])),
    .job_sq_i    (b_data[SQ_W:1]),
    .job_eos_i   (b_data[0]),
    .out_item_o  (out_item_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

endmodule
